[rtl/tdpf_pkg.sv]
// Package: shared field widths, mode and station codes for the track delta-phi feature stage.
`default_nettype none

package tdpf_pkg;

  localparam int MODE_W   = 4;
  localparam int DPHI_W   = 14;
  localparam int BEND_W   = 2;
  localparam int SUM4_W   = 17;
  localparam int SUM4A_W  = 16;
  localparam int SUM3_W   = 16;
  localparam int SUM3A_W  = 15;
  localparam int OUTST_W  = 3;

  localparam logic [MODE_W-1:0] FULL_MODE = 4'd15;

  // hit_mode bit positions
  localparam int HIT_ST1 = 3;
  localparam int HIT_ST2 = 2;
  localparam int HIT_ST3 = 1;
  localparam int HIT_ST4 = 0;

  // outlier station codes
  localparam logic [OUTST_W-1:0] OUTST_NONE = 3'd0;
  localparam logic [OUTST_W-1:0] OUTST_ST1  = 3'd1;
  localparam logic [OUTST_W-1:0] OUTST_ST2  = 3'd2;
  localparam logic [OUTST_W-1:0] OUTST_ST3  = 3'd3;
  localparam logic [OUTST_W-1:0] OUTST_ST4  = 3'd4;

  // bend sign codes
  localparam logic [BEND_W-1:0] BEND_ZERO = 2'b00;
  localparam logic [BEND_W-1:0] BEND_POS  = 2'b01;
  localparam logic [BEND_W-1:0] BEND_NEG  = 2'b11;

  // slots of the six pairwise differences
  localparam int D12 = 0;
  localparam int D13 = 1;
  localparam int D14 = 2;
  localparam int D23 = 3;
  localparam int D24 = 4;
  localparam int D34 = 5;
  localparam int N_DIFF = 6;

  // slots of the per-station sums (station n at slot n-1)
  localparam int N_STATION = 4;

endpackage

`default_nettype wire

[rtl/tdpf_if.sv]
// Interfaces: input item channel and result item channel with valid/ready handshake.
`default_nettype none

interface tdpf_in_if #(
  parameter int PHI_BITS = 13
);
  import tdpf_pkg::*;

  logic                valid;
  logic                ready;
  logic [PHI_BITS-1:0] phi_st1;
  logic [PHI_BITS-1:0] phi_st2;
  logic [PHI_BITS-1:0] phi_st3;
  logic [PHI_BITS-1:0] phi_st4;
  logic [MODE_W-1:0]   hit_mode;

  modport source (output valid, phi_st1, phi_st2, phi_st3, phi_st4, hit_mode, input ready);
  modport sink   (input valid, phi_st1, phi_st2, phi_st3, phi_st4, hit_mode, output ready);
endinterface

interface tdpf_out_if;
  import tdpf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [DPHI_W-1:0]   dphi_12;
  logic signed [DPHI_W-1:0]   dphi_13;
  logic signed [DPHI_W-1:0]   dphi_14;
  logic signed [DPHI_W-1:0]   dphi_23;
  logic signed [DPHI_W-1:0]   dphi_24;
  logic signed [DPHI_W-1:0]   dphi_34;
  logic signed [BEND_W-1:0]   bend_sign;
  logic signed [SUM4_W-1:0]   sum_four;
  logic        [SUM4A_W-1:0]  sum_four_abs;
  logic signed [SUM3_W-1:0]   sum_three;
  logic        [SUM3A_W-1:0]  sum_three_abs;
  logic        [OUTST_W-1:0]  outlier_station;

  modport source (output valid, dphi_12, dphi_13, dphi_14, dphi_23, dphi_24, dphi_34,
                  bend_sign, sum_four, sum_four_abs, sum_three, sum_three_abs,
                  outlier_station, input ready);
  modport sink   (input valid, dphi_12, dphi_13, dphi_14, dphi_23, dphi_24, dphi_34,
                  bend_sign, sum_four, sum_four_abs, sum_three, sum_three_abs,
                  outlier_station, output ready);
endinterface

`default_nettype wire

[rtl/track_delta_phi_features.sv]
// Top level: four-stage pipeline forming sign-normalized delta-phi track features.
`default_nettype none

//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in_ch   | sink      | valid/ready        | phi_st1..phi_st4 (PHI_BITS), hit_mode (4)
//  out_ch  | source    | valid/ready        | dphi_xx (6 x 14 s), bend_sign, sums, outlier
//
//  One item enters per clock while out_ch does not stall; each item passes through the
//  four register stages in order: raw differences, sign normalization and magnitudes,
//  multi-operand sums, outlier pick and output register.
//  Every stage has its own valid bit and advances when empty or when the stage after it
//  advances, so a stall on out_ch fills bubbles first and loses or repeats no item.
//  rst_n (synchronous, active low) clears the valid bits only.

module track_delta_phi_features #(
  parameter int PHI_BITS = 13
) (
  input  wire         clk,
  input  wire         rst_n,
  tdpf_in_if.sink     in_ch,
  tdpf_out_if.source  out_ch
);
  import tdpf_pkg::*;

  // Working width: six-term sums of PHI_BITS+1 differences, at least the widest field.
  localparam int SW = (PHI_BITS + 4 > SUM4_W) ? PHI_BITS + 4 : SUM4_W;

  // ---------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic en1, en2, en3, en4;

  assign en4 = !out_v_r || out_ch.ready;
  assign en3 = !s3_v_r  || en4;
  assign en2 = !s2_v_r  || en3;
  assign en1 = !s1_v_r  || en2;

  assign in_ch.ready = en1;

  // ---------------------------------------------------------------------------
  // Stage 1: raw pairwise differences and bend sign from the first hit pair.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] p1, p2, p3, p4;
  logic signed [SW-1:0] raw_d [N_DIFF];
  logic signed [SW-1:0] pair;
  logic                 have_pair;
  logic                 h1, h2, h3, h4;

  assign p1 = $signed({{(SW-PHI_BITS){1'b0}}, in_ch.phi_st1});
  assign p2 = $signed({{(SW-PHI_BITS){1'b0}}, in_ch.phi_st2});
  assign p3 = $signed({{(SW-PHI_BITS){1'b0}}, in_ch.phi_st3});
  assign p4 = $signed({{(SW-PHI_BITS){1'b0}}, in_ch.phi_st4});

  assign raw_d[D12] = p2 - p1;
  assign raw_d[D13] = p3 - p1;
  assign raw_d[D14] = p4 - p1;
  assign raw_d[D23] = p3 - p2;
  assign raw_d[D24] = p4 - p2;
  assign raw_d[D34] = p4 - p3;

  assign h1 = in_ch.hit_mode[HIT_ST1];
  assign h2 = in_ch.hit_mode[HIT_ST2];
  assign h3 = in_ch.hit_mode[HIT_ST3];
  assign h4 = in_ch.hit_mode[HIT_ST4];

  // Pick the difference between the two lowest-numbered hit stations.
  always_comb begin
    pair      = '0;
    have_pair = 1'b1;
    if (h1) begin
      if (h2)      pair = raw_d[D12];
      else if (h3) pair = raw_d[D13];
      else if (h4) pair = raw_d[D14];
      else         have_pair = 1'b0;
    end else if (h2) begin
      if (h3)      pair = raw_d[D23];
      else if (h4) pair = raw_d[D24];
      else         have_pair = 1'b0;
    end else if (h3) begin
      if (h4)      pair = raw_d[D34];
      else         have_pair = 1'b0;
    end else begin
      have_pair = 1'b0;
    end
  end

  logic signed [SW-1:0]     s1_d_r [N_DIFF];
  logic [BEND_W-1:0]        s1_sgn_r;
  logic                     s1_full_r;
  logic [BEND_W-1:0]        s1_sgn_nxt;

  // Zero difference counts as a positive bend.
  assign s1_sgn_nxt = !have_pair ? BEND_ZERO : (pair[SW-1] ? BEND_NEG : BEND_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_d_r    <= raw_d;
      s1_sgn_r  <= s1_sgn_nxt;
      s1_full_r <= (in_ch.hit_mode == FULL_MODE);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: apply the bend sign, form magnitudes.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] s2_d_nxt [N_DIFF];
  logic signed [SW-1:0] s2_a_nxt [N_DIFF];

  always_comb begin
    for (int i = 0; i < N_DIFF; i++) begin
      case (s1_sgn_r)
        BEND_POS: s2_d_nxt[i] = s1_d_r[i];
        BEND_NEG: s2_d_nxt[i] = -s1_d_r[i];
        default:  s2_d_nxt[i] = '0;
      endcase
      s2_a_nxt[i] = s1_d_r[i][SW-1] ? -s1_d_r[i] : s1_d_r[i];
    end
  end

  logic signed [SW-1:0] s2_d_r [N_DIFF];
  logic signed [SW-1:0] s2_a_r [N_DIFF];
  logic [BEND_W-1:0]    s2_sgn_r;
  logic                 s2_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_d_r    <= s2_d_nxt;
      s2_a_r    <= s2_a_nxt;
      s2_sgn_r  <= s1_sgn_r;
      s2_full_r <= s1_full_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: station deviations, full sums and the four three-station candidates.
  // Candidate slot n-1 leaves out station n.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] dev_nxt  [N_STATION];
  logic signed [SW-1:0] s3c_nxt  [N_STATION];
  logic signed [SW-1:0] s3ac_nxt [N_STATION];
  logic signed [SW-1:0] s4_nxt, s4a_nxt;

  assign dev_nxt[0] = s2_a_r[D12] + s2_a_r[D13] + s2_a_r[D14];
  assign dev_nxt[1] = s2_a_r[D12] + s2_a_r[D23] + s2_a_r[D24];
  assign dev_nxt[2] = s2_a_r[D13] + s2_a_r[D23] + s2_a_r[D34];
  assign dev_nxt[3] = s2_a_r[D14] + s2_a_r[D24] + s2_a_r[D34];

  assign s4_nxt  = s2_d_r[D12] + s2_d_r[D13] + s2_d_r[D14]
                 + s2_d_r[D23] + s2_d_r[D24] + s2_d_r[D34];
  assign s4a_nxt = s2_a_r[D12] + s2_a_r[D13] + s2_a_r[D14]
                 + s2_a_r[D23] + s2_a_r[D24] + s2_a_r[D34];

  assign s3c_nxt[0]  = s2_d_r[D23] + s2_d_r[D24] + s2_d_r[D34];
  assign s3c_nxt[1]  = s2_d_r[D13] + s2_d_r[D14] + s2_d_r[D34];
  assign s3c_nxt[2]  = s2_d_r[D12] + s2_d_r[D14] + s2_d_r[D24];
  assign s3c_nxt[3]  = s2_d_r[D12] + s2_d_r[D13] + s2_d_r[D23];
  assign s3ac_nxt[0] = s2_a_r[D23] + s2_a_r[D24] + s2_a_r[D34];
  assign s3ac_nxt[1] = s2_a_r[D13] + s2_a_r[D14] + s2_a_r[D34];
  assign s3ac_nxt[2] = s2_a_r[D12] + s2_a_r[D14] + s2_a_r[D24];
  assign s3ac_nxt[3] = s2_a_r[D12] + s2_a_r[D13] + s2_a_r[D23];

  logic signed [SW-1:0] s3_d_r    [N_DIFF];
  logic signed [SW-1:0] s3_dev_r  [N_STATION];
  logic signed [SW-1:0] s3_s3c_r  [N_STATION];
  logic signed [SW-1:0] s3_s3ac_r [N_STATION];
  logic signed [SW-1:0] s3_s4_r, s3_s4a_r;
  logic [BEND_W-1:0]    s3_sgn_r;
  logic                 s3_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_d_r    <= s2_d_r;
      s3_dev_r  <= dev_nxt;
      s3_s3c_r  <= s3c_nxt;
      s3_s3ac_r <= s3ac_nxt;
      s3_s4_r   <= s4_nxt;
      s3_s4a_r  <= s4a_nxt;
      s3_sgn_r  <= s2_sgn_r;
      s3_full_r <= s2_full_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: strict-maximum outlier pick, candidate select, zero outside full mode.
  // Priority runs station 4 down to station 1; no strict maximum leaves out station 1.
  // ---------------------------------------------------------------------------
  logic [N_STATION-1:0] top;
  logic [OUTST_W-1:0]   outst;
  logic signed [SW-1:0] s3_sel, s3a_sel;

  always_comb begin
    for (int i = 0; i < N_STATION; i++) begin
      top[i] = 1'b1;
      for (int j = 0; j < N_STATION; j++) begin
        if (j != i && !(s3_dev_r[i] > s3_dev_r[j])) top[i] = 1'b0;
      end
    end
  end

  always_comb begin
    if (top[3])      outst = OUTST_ST4;
    else if (top[2]) outst = OUTST_ST3;
    else if (top[1]) outst = OUTST_ST2;
    else if (top[0]) outst = OUTST_ST1;
    else             outst = OUTST_NONE;
  end

  always_comb begin
    case (outst)
      OUTST_ST4: begin
        s3_sel  = s3_s3c_r[3];
        s3a_sel = s3_s3ac_r[3];
      end
      OUTST_ST3: begin
        s3_sel  = s3_s3c_r[2];
        s3a_sel = s3_s3ac_r[2];
      end
      OUTST_ST2: begin
        s3_sel  = s3_s3c_r[1];
        s3a_sel = s3_s3ac_r[1];
      end
      default: begin
        s3_sel  = s3_s3c_r[0];
        s3a_sel = s3_s3ac_r[0];
      end
    endcase
  end

  logic signed [DPHI_W-1:0]  o_d_r [N_DIFF];
  logic [BEND_W-1:0]         o_sgn_r;
  logic [SUM4_W-1:0]         o_s4_r;
  logic [SUM4A_W-1:0]        o_s4a_r;
  logic [SUM3_W-1:0]         o_s3_r;
  logic [SUM3A_W-1:0]        o_s3a_r;
  logic [OUTST_W-1:0]        o_outst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en4) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int i = 0; i < N_DIFF; i++) begin
        o_d_r[i] <= s3_d_r[i][DPHI_W-1:0];
      end
      o_sgn_r   <= s3_sgn_r;
      o_s4_r    <= s3_full_r ? s3_s4_r[SUM4_W-1:0]   : '0;
      o_s4a_r   <= s3_full_r ? s3_s4a_r[SUM4A_W-1:0] : '0;
      o_s3_r    <= s3_full_r ? s3_sel[SUM3_W-1:0]    : '0;
      o_s3a_r   <= s3_full_r ? s3a_sel[SUM3A_W-1:0]  : '0;
      o_outst_r <= s3_full_r ? outst                 : OUTST_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------
  assign out_ch.valid           = out_v_r;
  assign out_ch.dphi_12         = o_d_r[D12];
  assign out_ch.dphi_13         = o_d_r[D13];
  assign out_ch.dphi_14         = o_d_r[D14];
  assign out_ch.dphi_23         = o_d_r[D23];
  assign out_ch.dphi_24         = o_d_r[D24];
  assign out_ch.dphi_34         = o_d_r[D34];
  assign out_ch.bend_sign       = $signed(o_sgn_r);
  assign out_ch.sum_four        = $signed(o_s4_r);
  assign out_ch.sum_four_abs    = o_s4a_r;
  assign out_ch.sum_three       = $signed(o_s3_r);
  assign out_ch.sum_three_abs   = o_s3a_r;
  assign out_ch.outlier_station = o_outst_r;

endmodule

`default_nettype wire
